/* rtl/core/btmx_pkg.sv */
// shared types, constants and codes for the binary trie max-xor block
`default_nettype none

package btmx_pkg;

    // key and trie geometry
    localparam int KEY_WIDTH   = 32;
    localparam int NODE_COUNT  = 32768;
    localparam int COUNT_WIDTH = 16;

    localparam int NODE_W   = $clog2(NODE_COUNT);
    localparam int FREE_W   = NODE_W + 1;
    localparam int LEVEL_W  = $clog2(KEY_WIDTH);
    localparam int NEED_W   = $clog2(KEY_WIDTH + 1);
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    localparam logic [LEVEL_W-1:0] LVL_TOP = LEVEL_W'(KEY_WIDTH - 1);

    typedef logic [NODE_W-1:0]      node_idx_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    localparam count_t CNT_MAX = '1;

    // one pool entry: links and counts of both children live in the parent
    typedef struct packed {
        count_t     cnt_one;
        count_t     cnt_zero;
        node_idx_t  link_one;
        node_idx_t  link_zero;
        logic [1:0] present;
    } node_t;

    localparam int NODE_BITS = $bits(node_t);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_POOL_FULL = 3'd1,
        ST_ABSENT    = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_OVERFLOW  = 3'd4
    } status_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS1,
        S_DECIDE,
        S_PASS2,
        S_RESP
    } ctl_state_e;

    // control from the sequencer to the walk datapath
    typedef struct packed {
        logic accept;
        logic clear;
        cmd_e cmd;
        logic pass1;
        logic decide;
        logic pass2;
        logic top;
        logic load;
    } walk_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/btmx_ram.sv */
// generic simple dual-port ram with registered read
`default_nettype none

module btmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/btmx_ctrl.sv */
// sequencer: request handshake, level counter, pass control and result valid
`default_nettype none

module btmx_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic [btmx_pkg::CMD_W-1:0]     cmd,
    input  wire logic                           out_stall,
    input  wire logic                           fail,
    output logic                                in_stall,
    output logic                                out_valid,
    output btmx_pkg::walk_ctl_t                 ctl
);

    btmx_pkg::ctl_state_e             state_reg, state_next;
    btmx_pkg::cmd_e                   cmd_reg, cmd_next;
    logic [btmx_pkg::LEVEL_W-1:0]     level_reg, level_next;
    logic                             out_valid_reg, out_valid_next;
    logic                             out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= btmx_pkg::S_IDLE;
            cmd_reg       <= btmx_pkg::CMD_INSERT;
            level_reg     <= btmx_pkg::LVL_TOP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state, level count and result valid
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        level_next     = level_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            btmx_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = btmx_pkg::cmd_e'(cmd);
                    level_next = btmx_pkg::LVL_TOP;
                    if (btmx_pkg::cmd_e'(cmd) == btmx_pkg::CMD_CLEAR)
                    begin
                        state_next = btmx_pkg::S_RESP;
                    end
                    else
                    begin
                        state_next = btmx_pkg::S_PASS1;
                    end
                end
            end
            btmx_pkg::S_PASS1:
            begin
                if (level_reg == '0)
                begin
                    level_next = btmx_pkg::LVL_TOP;
                    if (cmd_reg == btmx_pkg::CMD_QUERY)
                    begin
                        state_next = btmx_pkg::S_RESP;
                    end
                    else
                    begin
                        state_next = btmx_pkg::S_DECIDE;
                    end
                end
                else
                begin
                    level_next = level_reg - 1'b1;
                end
            end
            btmx_pkg::S_DECIDE:
            begin
                state_next = fail ? btmx_pkg::S_RESP : btmx_pkg::S_PASS2;
            end
            btmx_pkg::S_PASS2:
            begin
                if (level_reg == '0)
                begin
                    level_next = btmx_pkg::LVL_TOP;
                    state_next = btmx_pkg::S_RESP;
                end
                else
                begin
                    level_next = level_reg - 1'b1;
                end
            end
            btmx_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = btmx_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = btmx_pkg::S_IDLE;
            end
        endcase
    end

    // outputs decoded from state
    always_comb
    begin
        in_stall   = 1'b1;
        out_valid  = out_valid_reg;
        ctl        = '0;
        ctl.cmd    = cmd_reg;
        ctl.top    = (level_reg == btmx_pkg::LVL_TOP);
        unique case (state_reg)
            btmx_pkg::S_IDLE:
            begin
                in_stall   = 1'b0;
                ctl.accept = in_valid;
                ctl.clear  = in_valid &&
                             (btmx_pkg::cmd_e'(cmd) == btmx_pkg::CMD_CLEAR);
            end
            btmx_pkg::S_PASS1:  ctl.pass1  = 1'b1;
            btmx_pkg::S_DECIDE: ctl.decide = 1'b1;
            btmx_pkg::S_PASS2:  ctl.pass2  = 1'b1;
            btmx_pkg::S_RESP:   ctl.load   = out_free;
            default:            ctl.load   = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/btmx_path.sv */
// walk datapath: key rotator, node update, root entry, allocator and result shifter
`default_nettype none

module btmx_path (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire btmx_pkg::walk_ctl_t               ctl,
    input  wire logic [btmx_pkg::KEY_WIDTH-1:0]    key_value,
    output logic                                   fail,
    output logic [btmx_pkg::KEY_WIDTH-1:0]         best_xor,
    output logic [btmx_pkg::STATUS_W-1:0]          status,
    output logic                                   ram_wr_en,
    output btmx_pkg::node_idx_t                    ram_wr_addr,
    output logic [btmx_pkg::NODE_BITS-1:0]         ram_wr_data,
    output logic                                   ram_rd_en,
    output btmx_pkg::node_idx_t                    ram_rd_addr,
    input  wire logic [btmx_pkg::NODE_BITS-1:0]    ram_rd_data
);

    localparam int KW = btmx_pkg::KEY_WIDTH;
    localparam int SW = btmx_pkg::FREE_W + 1;

    // registers
    logic [KW-1:0]                  key_reg, key_next;
    logic [KW-1:0]                  sr_reg, sr_next;
    btmx_pkg::node_idx_t            u_reg, u_next;
    logic                           fresh_reg, fresh_next;
    logic                           alive_reg, alive_next;
    logic                           over_reg, over_next;
    logic [btmx_pkg::NEED_W-1:0]    need_reg, need_next;
    btmx_pkg::status_e              st_reg, st_next;
    btmx_pkg::node_t                root_reg, root_next;
    logic [btmx_pkg::FREE_W-1:0]    free_reg, free_next;
    logic [KW-1:0]                  best_reg;
    logic [btmx_pkg::STATUS_W-1:0]  status_reg;

    // current level decode
    btmx_pkg::node_t                cur, upd;
    logic                           c, has_c, has_o, ok_in, take_o, alloc, walk, miss;
    btmx_pkg::count_t               cnt_c, cnt_o, cc_c, cc_o, cnt_new;
    btmx_pkg::node_idx_t            link_c, link_o, link_new, nxt, free_idx;
    logic                           pool_full, is_insert;

    assign walk      = ctl.pass1 || ctl.pass2;
    assign is_insert = (ctl.cmd == btmx_pkg::CMD_INSERT);
    assign free_idx  = free_reg[btmx_pkg::NODE_W-1:0];

    // node at the current level: root entry, a fresh node, or the ram word
    always_comb
    begin
        if (ctl.top)
        begin
            cur = root_reg;
        end
        else if (fresh_reg)
        begin
            cur = '0;
        end
        else
        begin
            cur = btmx_pkg::node_t'(ram_rd_data);
        end
        c      = key_reg[KW-1];
        has_c  = c ? cur.present[1] : cur.present[0];
        has_o  = c ? cur.present[0] : cur.present[1];
        cnt_c  = c ? cur.cnt_one : cur.cnt_zero;
        cnt_o  = c ? cur.cnt_zero : cur.cnt_one;
        link_c = c ? cur.link_one : cur.link_zero;
        link_o = c ? cur.link_zero : cur.link_one;
        cc_c   = has_c ? cnt_c : '0;
        cc_o   = has_o ? cnt_o : '0;
        ok_in  = ctl.top || alive_reg;
        miss   = !(ok_in && has_c);
        take_o = ok_in && (cc_o != '0);
    end

    // updated entry and next node for the commit pass
    always_comb
    begin
        alloc    = ctl.pass2 && is_insert && !has_c;
        link_new = alloc ? free_idx : link_c;
        if (is_insert)
        begin
            cnt_new = has_c ? (cnt_c + 1'b1) : btmx_pkg::count_t'(1);
        end
        else
        begin
            cnt_new = cnt_c - 1'b1;
        end
        upd = cur;
        if (c)
        begin
            upd.cnt_one  = cnt_new;
            upd.link_one = link_new;
        end
        else
        begin
            upd.cnt_zero  = cnt_new;
            upd.link_zero = link_new;
        end
        if (is_insert)
        begin
            upd.present = cur.present | (c ? 2'b10 : 2'b01);
        end
        if (ctl.pass1 && (ctl.cmd == btmx_pkg::CMD_QUERY) && take_o)
        begin
            nxt = link_o;
        end
        else
        begin
            nxt = link_new;
        end
    end

    // pool check and failure decision after the check pass
    assign pool_full = ({1'b0, free_reg} + SW'(need_reg)) > SW'(btmx_pkg::NODE_COUNT);
    assign fail      = is_insert ? (pool_full || over_reg) : !alive_reg;

    // next values of the walk registers
    always_comb
    begin
        key_next   = key_reg;
        sr_next    = sr_reg;
        u_next     = u_reg;
        fresh_next = fresh_reg;
        alive_next = alive_reg;
        over_next  = over_reg;
        need_next  = need_reg;
        st_next    = st_reg;
        root_next  = root_reg;
        free_next  = free_reg;

        if (ctl.accept)
        begin
            key_next = key_value;
            sr_next  = '0;
            st_next  = btmx_pkg::ST_OK;
        end
        if (ctl.clear)
        begin
            root_next.present = '0;
            free_next         = btmx_pkg::FREE_W'(1);
        end

        // one key bit per level, rotated so the second pass sees it again
        if (walk)
        begin
            key_next   = {key_reg[KW-2:0], key_reg[KW-1]};
            u_next     = nxt;
            fresh_next = alloc;
        end

        if (ctl.pass1)
        begin
            unique case (ctl.cmd)
                btmx_pkg::CMD_INSERT:
                begin
                    alive_next = !miss;
                    over_next  = (!ctl.top && over_reg) || (!miss && (cnt_c == btmx_pkg::CNT_MAX));
                    need_next  = (ctl.top ? '0 : need_reg) +
                                 {{(btmx_pkg::NEED_W-1){1'b0}}, miss};
                end
                btmx_pkg::CMD_REMOVE:
                begin
                    alive_next = ok_in && (cc_c != '0);
                end
                btmx_pkg::CMD_QUERY:
                begin
                    alive_next = take_o || (ok_in && (cc_c != '0));
                    sr_next    = {sr_reg[KW-2:0], take_o};
                    if (ctl.top && !alive_next)
                    begin
                        st_next = btmx_pkg::ST_EMPTY;
                    end
                end
                default:
                begin
                    alive_next = alive_reg;
                end
            endcase
        end

        if (ctl.decide && fail)
        begin
            if (!is_insert)
            begin
                st_next = btmx_pkg::ST_ABSENT;
            end
            else if (pool_full)
            begin
                st_next = btmx_pkg::ST_POOL_FULL;
            end
            else
            begin
                st_next = btmx_pkg::ST_OVERFLOW;
            end
        end

        // commit pass: root entry lives in flops, new nodes come off the counter
        if (ctl.pass2)
        begin
            if (ctl.top)
            begin
                root_next = upd;
            end
            if (alloc)
            begin
                free_next = free_reg + 1'b1;
            end
        end
    end

    // trie state that reset defines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= '0;
            free_reg <= btmx_pkg::FREE_W'(1);
        end
        else
        begin
            root_reg <= root_next;
            free_reg <= free_next;
        end
    end

    // walk payload registers
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        sr_reg    <= sr_next;
        u_reg     <= u_next;
        fresh_reg <= fresh_next;
        alive_reg <= alive_next;
        over_reg  <= over_next;
        need_reg  <= need_next;
        st_reg    <= st_next;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            best_reg   <= sr_reg;
            status_reg <= st_reg;
        end
    end

    assign best_xor = best_reg;
    assign status   = status_reg;

    // node pool access: write back the current node, fetch the next one
    assign ram_wr_en   = ctl.pass2 && !ctl.top;
    assign ram_wr_addr = u_reg;
    assign ram_wr_data = upd;
    assign ram_rd_en   = walk;
    assign ram_rd_addr = nxt;

endmodule

`default_nettype wire

/* rtl/core/binary_trie_max_xor.sv */
// top level of the binary trie max-xor engine
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------
//  request  | in_valid / in_stall | cmd[1:0], key_value[31:0]
//  result   | out_valid/out_stall | best_xor[31:0], status[2:0]
//
// clear goes straight to its result; query makes one pass over the 32 levels; insert and remove
// make two 32-level passes with a decision between them, and stop after the first pass when they fail.
// each level reads the next node from the pool; the commit pass also writes the current node back.
// the root entry sits in flops, so reset needs no clearing pass over the pool.
// async active-low reset empties the trie; pool words are written before use.
// a new request is taken while the previous result waits in the output register.
`default_nettype none

module binary_trie_max_xor (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [btmx_pkg::CMD_W-1:0]         cmd,
    input  wire logic [btmx_pkg::KEY_WIDTH-1:0]     key_value,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [btmx_pkg::KEY_WIDTH-1:0]          best_xor,
    output logic [btmx_pkg::STATUS_W-1:0]           status
);

    btmx_pkg::walk_ctl_t                 ctl;
    logic                                fail;
    logic                                ram_wr_en, ram_rd_en;
    btmx_pkg::node_idx_t                 ram_wr_addr, ram_rd_addr;
    logic [btmx_pkg::NODE_BITS-1:0]      ram_wr_data, ram_rd_data;

    // sequencer
    btmx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .out_stall (out_stall),
        .fail      (fail),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .ctl       (ctl)
    );

    // walk datapath
    btmx_path u_path (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .key_value   (key_value),
        .fail        (fail),
        .best_xor    (best_xor),
        .status      (status),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // node pool
    btmx_ram #(
        .WIDTH (btmx_pkg::NODE_BITS),
        .DEPTH (btmx_pkg::NODE_COUNT)
    ) u_pool (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // a taken request keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request taken while busy");

    // a successful decision starts the commit pass at the root
    a_commit_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.decide && !fail) |=> (ctl.pass2 && ctl.top))
        else $error("commit pass did not start at the root");

    // a result appears only after the output register was loaded
    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(ctl.load))
        else $error("result valid without a load");

    // the pool is only written during the commit pass below the root
    a_write_in_commit: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (ctl.pass2 && !ctl.top && !ctl.accept))
        else $error("pool write outside the commit pass");

endmodule

`default_nettype wire

/* sim/binary_trie_max_xor_checker.sv */
// checker for the trie max-xor block: predicts every result and compares it
`timescale 1ns / 100ps

module binary_trie_max_xor_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_stall,
    input  wire logic [btmx_pkg::CMD_W-1:0]     cmd,
    input  wire logic [btmx_pkg::KEY_WIDTH-1:0] key_value,
    input  wire logic                           out_valid,
    input  wire logic                           out_stall,
    input  wire logic [btmx_pkg::KEY_WIDTH-1:0] best_xor,
    input  wire logic [btmx_pkg::STATUS_W-1:0]  status,
    output int                                  fail_count,
    output int                                  outstanding
);
    import btmx_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct {
        cmd_e                 op;
        logic [KEY_WIDTH-1:0] key;
        logic [KEY_WIDTH-1:0] best;
        status_e              st;
    } trie_result_t;

    // results owed for requests already taken, oldest first
    trie_result_t open_results[$];

    // shadow trie: links, presence mask and pass count per node
    node_idx_t  link_zero [NODE_COUNT];
    node_idx_t  link_one  [NODE_COUNT];
    logic [1:0] has_kid   [NODE_COUNT];
    count_t     through   [NODE_COUNT];
    int         next_node;

    function automatic node_idx_t kid(input int u, input logic c);
        return c ? link_one[u] : link_zero[u];
    endfunction

    // a missing child counts as empty
    function automatic count_t kid_count(input int u, input logic c);
        return has_kid[u][c] ? through[kid(u, c)] : '0;
    endfunction

    function automatic status_e trie_insert(input logic [KEY_WIDTH-1:0] k);
        int        u;
        int        i;
        int        need;
        logic      over;
        logic      c;
        node_idx_t v;
        u    = 0;
        need = 0;
        over = 1'b0;
        // dry walk: nodes still to allocate and saturated counts on the path
        for (i = KEY_WIDTH - 1; i >= 0; i--) begin
            c = k[i];
            if (need == 0 && has_kid[u][c]) begin
                u = kid(u, c);
                if (through[u] == CNT_MAX)
                    over = 1'b1;
            end else begin
                need++;
            end
        end
        if (next_node + need > NODE_COUNT)
            return ST_POOL_FULL;
        if (over)
            return ST_OVERFLOW;
        // real walk: allocate missing nodes and bump counts
        u = 0;
        for (i = KEY_WIDTH - 1; i >= 0; i--) begin
            c = k[i];
            if (!has_kid[u][c]) begin
                v = node_idx_t'(next_node);
                next_node++;
                link_zero[v] = '0;
                link_one[v]  = '0;
                has_kid[v]   = 2'b00;
                through[v]   = '0;
                if (c)
                    link_one[u] = v;
                else
                    link_zero[u] = v;
                has_kid[u][c] = 1'b1;
            end
            v = kid(u, c);
            through[v] = through[v] + 1'b1;
            u = v;
        end
        return ST_OK;
    endfunction

    function automatic status_e trie_remove(input logic [KEY_WIDTH-1:0] k);
        int        u;
        int        i;
        node_idx_t v;
        // key must have a live path all the way down
        u = 0;
        for (i = KEY_WIDTH - 1; i >= 0; i--) begin
            if (kid_count(u, k[i]) == 0)
                return ST_ABSENT;
            u = kid(u, k[i]);
        end
        u = 0;
        for (i = KEY_WIDTH - 1; i >= 0; i--) begin
            v = kid(u, k[i]);
            through[v] = through[v] - 1'b1;
            u = v;
        end
        return ST_OK;
    endfunction

    function automatic status_e trie_query(input  logic [KEY_WIDTH-1:0] k,
                                           output logic [KEY_WIDTH-1:0] best);
        int   u;
        int   i;
        logic c;
        best = '0;
        if (kid_count(0, 1'b0) == 0 && kid_count(0, 1'b1) == 0)
            return ST_EMPTY;
        // greedy walk toward the opposite bit, stop on a broken path
        u = 0;
        for (i = KEY_WIDTH - 1; i >= 0; i--) begin
            c = k[i];
            if (kid_count(u, ~c) != 0) begin
                best[i] = 1'b1;
                u = kid(u, ~c);
            end else if (kid_count(u, c) != 0) begin
                u = kid(u, c);
            end else begin
                break;
            end
        end
        return ST_OK;
    endfunction

    function automatic trie_result_t trie_predict(input cmd_e op,
                                                  input logic [KEY_WIDTH-1:0] k);
        trie_result_t r;
        r.op   = op;
        r.key  = k;
        r.best = '0;
        r.st   = ST_OK;
        case (op)
            CMD_INSERT: r.st = trie_insert(k);
            CMD_REMOVE: r.st = trie_remove(k);
            CMD_QUERY:  r.st = trie_query(k, r.best);
            default:
            begin
                has_kid[0] = 2'b00;
                through[0] = '0;
                next_node  = 1;
            end
        endcase
        return r;
    endfunction

    // compare taken results first, then book the request taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        trie_result_t want;
        if (!rst_n)
        begin
            has_kid[0] = 2'b00;
            through[0] = '0;
            next_node  = 1;
            open_results.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (open_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: result with no open request: best_xor %h status %0d",
                                 $time, best_xor, status);
                end
                else
                begin
                    want = open_results.pop_front();
                    if (best_xor !== want.best || status !== want.st)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("%0t: cmd %0d key %h: expected best_xor %h status %0d, %s",
                                     $time, want.op, want.key, want.best, want.st,
                                     $sformatf("got best_xor %h status %0d", best_xor, status));
                    end
                end
            end
            if (in_valid && !in_stall)
                open_results.push_back(trie_predict(cmd_e'(cmd), key_value));
            outstanding = open_results.size();
        end
    end

endmodule

/* sim/binary_trie_max_xor_tb.sv */
// testbench top: drives requests into the trie max-xor block and reports the verdict
`timescale 1ns / 100ps

module binary_trie_max_xor_tb;
    import btmx_pkg::*;

    localparam int RESET_CYCLES = 6;
    localparam int MIXED_COUNT  = 170;
    localparam int FILL_COUNT   = 1560;
    localparam int PHASE_LEN    = 40;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 2000000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [CMD_W-1:0]     cmd       = CMD_INSERT;
    logic [KEY_WIDTH-1:0] key_value = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [KEY_WIDTH-1:0] best_xor;
    logic [STATUS_W-1:0]  status;

    int fail_count;
    int outstanding;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // keys believed stored, and keys already taken out
    logic [KEY_WIDTH-1:0] live_keys[$];
    logic [KEY_WIDTH-1:0] gone_keys[$];

    binary_trie_max_xor u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .key_value (key_value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .best_xor  (best_xor),
        .status    (status)
    );

    binary_trie_max_xor_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .key_value   (key_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .best_xor    (best_xor),
        .status      (status),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // 0 none, 1 sender gaps, 2 receiver stalls, 3 both
    task automatic set_idle(input int mode);
        send_idle_pct  = (mode == 1) ? 68 : (mode == 3) ? 38 : 0;
        recv_stall_pct = (mode == 2) ? 68 : (mode == 3) ? 38 : 0;
    endtask

    // one request, entered and left at a falling edge
    task automatic send_request(input cmd_e op, input logic [KEY_WIDTH-1:0] k);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid  <= 1'b0;
            cmd       <= CMD_W'($urandom_range(3));
            key_value <= $urandom;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= op;
        key_value <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // keys: fully random, a tight family, neighbors of stored keys, walking bits
    function automatic logic [KEY_WIDTH-1:0] random_key();
        logic [KEY_WIDTH-1:0] k;
        case ($urandom_range(3))
            0: k = $urandom;
            1: k = (32'h5A3C_0000 ^ (32'($urandom_range(3)) << 20)) | 32'($urandom_range(63));
            2:
            begin
                if (live_keys.size() > 0)
                    k = live_keys[$urandom_range(live_keys.size() - 1)]
                        ^ (32'h1 << $urandom_range(KEY_WIDTH - 1));
                else
                    k = $urandom;
            end
            default:
            begin
                k = 32'h1 << $urandom_range(KEY_WIDTH - 1);
                if ($urandom_range(1))
                    k = ~k;
            end
        endcase
        return k;
    endfunction

    initial
    begin
        int                   n;
        int                   roll;
        int                   idx;
        logic [KEY_WIDTH-1:0] k;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty trie, extremes, duplicates, absent keys, clear
        send_request(CMD_QUERY,  32'h0000_0000);
        send_request(CMD_REMOVE, 32'h0000_0000);
        send_request(CMD_INSERT, 32'h0000_0000);
        send_request(CMD_INSERT, 32'hFFFF_FFFF);
        send_request(CMD_QUERY,  32'h0000_0000);
        send_request(CMD_QUERY,  32'hFFFF_FFFF);
        send_request(CMD_QUERY,  32'h0F0F_0F0F);
        send_request(CMD_INSERT, 32'h0000_0000);
        send_request(CMD_REMOVE, 32'h0000_0000);
        send_request(CMD_REMOVE, 32'h0000_0000);
        send_request(CMD_REMOVE, 32'h0000_0000);
        send_request(CMD_QUERY,  32'hFFFF_FFFF);
        send_request(CMD_REMOVE, 32'hFFFF_FFFF);
        send_request(CMD_QUERY,  32'h1234_5678);
        send_request(CMD_INSERT, 32'h8000_0000);
        send_request(CMD_INSERT, 32'h7FFF_FFFF);
        send_request(CMD_QUERY,  32'h0000_0001);
        send_request(CMD_REMOVE, 32'h8000_0001);
        send_request(CMD_REMOVE, 32'h4000_0000);
        send_request(CMD_CLEAR,  32'hFFFF_FFFF);
        send_request(CMD_QUERY,  32'h0000_0000);
        send_request(CMD_INSERT, 32'h1234_5678);
        send_request(CMD_QUERY,  32'hEDCB_A987);
        send_request(CMD_CLEAR,  32'h0000_0000);

        // mixed traffic: inserts, removes mostly of stored keys, queries, occasional clear
        for (n = 0; n < MIXED_COUNT; n++)
        begin
            set_idle((n / PHASE_LEN) % 4);
            roll = $urandom_range(99);
            if (roll < 40)
            begin
                if ($urandom_range(3) == 0 && live_keys.size() > 0)
                    k = live_keys[$urandom_range(live_keys.size() - 1)];
                else
                    k = random_key();
                live_keys.push_back(k);
                send_request(CMD_INSERT, k);
            end
            else if (roll < 65)
            begin
                if ($urandom_range(9) < 7 && live_keys.size() > 0)
                begin
                    idx = $urandom_range(live_keys.size() - 1);
                    k   = live_keys[idx];
                    live_keys.delete(idx);
                    gone_keys.push_back(k);
                end
                else if ($urandom_range(1) && gone_keys.size() > 0)
                    k = gone_keys[$urandom_range(gone_keys.size() - 1)];
                else
                    k = random_key();
                send_request(CMD_REMOVE, k);
            end
            else if (roll < 98)
                send_request(CMD_QUERY, random_key());
            else
            begin
                live_keys.delete();
                send_request(CMD_CLEAR, $urandom);
            end
        end

        // fill the node pool with scattered keys until inserts get refused
        live_keys.delete();
        send_request(CMD_CLEAR, $urandom);
        for (n = 0; n < FILL_COUNT; n++)
        begin
            set_idle((n / PHASE_LEN) % 4);
            roll = $urandom_range(99);
            if (roll < 96 || live_keys.size() == 0)
            begin
                k = $urandom;
                live_keys.push_back(k);
                send_request(CMD_INSERT, k);
            end
            else if (roll < 97)
                send_request(CMD_INSERT, live_keys[$urandom_range(live_keys.size() - 1)]);
            else if (roll < 99)
                send_request(CMD_QUERY, $urandom);
            else
            begin
                idx = $urandom_range(live_keys.size() - 1);
                send_request(CMD_REMOVE, live_keys[idx]);
                live_keys.delete(idx);
            end
        end

        // clear after a full pool, then reuse it
        send_request(CMD_CLEAR, $urandom);
        send_request(CMD_QUERY, $urandom);
        send_request(CMD_INSERT, 32'hFFFF_FFFF);
        send_request(CMD_QUERY, 32'h0000_0000);

        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
